// ----- rtl/core/implicit_array_bst_engine_defines.svh -----
// ----------------------------------------------------------------------------
// implicit_array_bst_engine_defines
// assertion macros shared by the bst engine rtl
// ----------------------------------------------------------------------------
`ifndef IMPLICIT_ARRAY_BST_ENGINE_DEFINES_SVH
`define IMPLICIT_ARRAY_BST_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define IABST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define IABST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IABST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IABST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/iabst_pkg.sv -----
// ----------------------------------------------------------------------------
// iabst_pkg
// types and constants of the implicit array bst engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iabst_pkg;

    localparam int KEY_W   = 32;
    localparam int CNT_W   = 4;
    localparam int SLOT_W  = 10;
    localparam int CNT_MAX = 15;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [SLOT_W-1:0]       t_slot;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_FIND   = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_WALK  = 3'b100
    } t_state;

endpackage

// ----- rtl/core/iabst_if.sv -----
// ----------------------------------------------------------------------------
// iabst_if
// request and response channels of the bst engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface iabst_req_if;
    import iabst_pkg::*;
    logic  valid;
    logic  ready;
    t_mode mode;
    t_key  key;
    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

interface iabst_rsp_if;
    import iabst_pkg::*;
    logic  valid;
    logic  ready;
    t_key  found_value;
    logic  was_duplicate;
    t_cnt  compare_count;
    t_slot slot_index;
    logic  overflow;
    modport source (output valid, output found_value, output was_duplicate,
                    output compare_count, output slot_index, output overflow,
                    input ready);
    modport sink   (input valid, input found_value, input was_duplicate,
                    input compare_count, input slot_index, input overflow,
                    output ready);
endinterface

// ----- rtl/core/implicit_array_bst_engine.sv -----
// ----------------------------------------------------------------------------
// implicit_array_bst_engine
// binary search tree in an implicit array store (children of p at 2p+1, 2p+2)
//
//   port    | dir | item
//   --------+-----+-------------------------------------------------------
//   i_req   | in  | mode, key
//   o_rsp   | out | found_value, was_duplicate, compare_count, slot_index,
//           |     | overflow
//
// one store read per tree level. after reset a clearing pass writes zero to
// all CAPACITY entries, one per cycle, with i_req.ready low.
// a result waiting in the output register does not block the next item; the
// walk holds at its last level while the output register is still full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "implicit_array_bst_engine_defines.svh"

module implicit_array_bst_engine #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iabst_req_if.sink   i_req,
    iabst_rsp_if.source o_rsp
);
    import iabst_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int NW = PW + 2;
    localparam int DW = $clog2(PW + 2);

    typedef logic signed [KEY_BITS-1:0] t_skey;

    t_state           r_state, n_state;
    logic [PW-1:0]    r_clr;
    logic [PW-1:0]    r_pos;
    logic [DW-1:0]    r_desc;
    t_skey            r_key;
    t_mode            r_mode;
    t_skey            r_rd_data;
    t_skey            r_mem [CAPACITY];

    logic             r_out_valid;
    t_key             r_found;
    logic             r_dup;
    t_cnt             r_cnt;
    t_slot            r_slot;
    logic             r_ovf;

    logic             w_accept;
    logic             w_zero, w_empty, w_match, w_ovf, w_stop;
    logic             w_out_free, w_finish, w_descend;
    logic [NW-1:0]    w_next;
    logic             w_rd_en;
    logic [PW-1:0]    w_rd_addr;
    logic             w_wr_en;
    logic [PW-1:0]    w_wr_addr;
    t_skey            w_wr_data;
    logic [DW:0]      w_cnt_full;
    t_cnt             w_cnt;

    // walk evaluation
    always_comb begin
        w_accept   = i_req.valid && i_req.ready;
        w_zero     = (r_key == '0);
        w_empty    = (r_rd_data == '0);
        w_match    = (r_rd_data == r_key);
        w_next     = {1'b0, r_pos, 1'b0} + ((r_key < r_rd_data) ? NW'(1) : NW'(2));
        w_ovf      = !w_zero && !w_empty && !w_match && (w_next >= NW'(CAPACITY));
        w_stop     = w_zero || w_empty || w_match || w_ovf;
        w_out_free = !r_out_valid || o_rsp.ready;
        w_finish   = (r_state == S_WALK) && w_stop && w_out_free;
        w_descend  = (r_state == S_WALK) && !w_stop;
        w_cnt_full = {1'b0, r_desc} + (DW+1)'(1);
        w_cnt      = (w_cnt_full > (DW+1)'(CNT_MAX)) ? CNT_W'(CNT_MAX)
                                                      : CNT_W'(w_cnt_full);
    end

    // store port control
    always_comb begin
        w_rd_en   = w_accept || w_descend;
        w_rd_addr = w_accept ? '0 : w_next[PW-1:0];
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = r_key;
        if (r_state == S_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr;
            w_wr_data = '0;
        end else if (w_finish && !w_zero && w_empty && (r_mode == MODE_INSERT)) begin
            w_wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == PW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + PW'(1);
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and walk position
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key  <= KEY_BITS'(i_req.key);
            r_mode <= i_req.mode;
            r_pos  <= '0;
            r_desc <= '0;
        end else if (w_descend) begin
            r_pos  <= w_next[PW-1:0];
            r_desc <= r_desc + DW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_found <= (!w_zero && w_match && (r_mode == MODE_FIND)) ? KEY_W'(r_key) : '0;
            r_dup   <= !w_zero && w_match && (r_mode == MODE_INSERT);
            r_cnt   <= (!w_zero && w_match && (r_mode == MODE_INSERT)) ? w_cnt : '0;
            r_slot  <= (w_zero || w_ovf) ? '0 : SLOT_W'(r_pos);
            r_ovf   <= w_ovf;
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.found_value   = r_found;
    assign o_rsp.was_duplicate = r_dup;
    assign o_rsp.compare_count = r_cnt;
    assign o_rsp.slot_index    = r_slot;
    assign o_rsp.overflow      = r_ovf;

    `IABST_ASSERT_IMP(a_ins_write_empty, i_clk, i_rst_n, w_wr_en && (r_state != S_CLEAR), (r_mode == MODE_INSERT) && w_empty && !w_zero)
    `IABST_ASSERT_IMP(a_ovf_no_write, i_clk, i_rst_n, w_finish && w_ovf, !w_wr_en)
    `IABST_ASSERT_IMP(a_pos_in_range, i_clk, i_rst_n, r_state == S_WALK, r_pos <= PW'(CAPACITY - 1))
    `IABST_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, w_finish, !r_out_valid || o_rsp.ready)
    `IABST_ASSERT_NXT(a_finish_sets_valid, i_clk, i_rst_n, w_finish, r_out_valid && (r_state == S_IDLE))

endmodule

// ----- bench/implicit_array_bst_engine_test.sv -----
// ----------------------------------------------------------------------------
// implicit_array_bst_engine_test
// self-checking bench for the implicit array bst engine: a queue-fed driver
// offers insert and find items, a local tree walk predicts every result and
// a monitor compares each response field by field, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module implicit_array_bst_engine_test;
    import iabst_pkg::*;

    localparam int CAPACITY     = 1024;
    localparam int RANDOM_ITEMS = 380;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 120;
    localparam int QUIET_FROM   = 200;
    localparam int QUIET_TO     = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 10000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        t_mode mode;
        t_key  key;
    } t_request;

    typedef struct {
        t_key  found_value;
        logic  was_duplicate;
        t_cnt  compare_count;
        t_slot slot_index;
        logic  overflow;
    } t_walk_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic  req_valid = 1'b0;
    t_mode req_mode  = MODE_INSERT;
    t_key  req_key   = '0;
    logic  rsp_ready = 1'b0;

    iabst_req_if req_ch ();
    iabst_rsp_if rsp_ch ();

    assign req_ch.valid = req_valid;
    assign req_ch.mode  = req_mode;
    assign req_ch.key   = req_key;
    assign rsp_ch.ready = rsp_ready;

    implicit_array_bst_engine #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #10 i_clk = ~i_clk;

    t_key         tree_slots [CAPACITY];
    t_request     pending_reqs [$];
    t_walk_result due_results [$];
    t_key         queued_keys [$];

    int  reqs_accepted = 0;
    int  mismatches    = 0;
    int  stall_cycles  = 0;
    int  hold_left     = 0;
    bit  pressure_done = 1'b0;

    t_request     next_req;
    t_walk_result got_result;
    t_walk_result exp_result;

    initial begin
        for (int i = 0; i < CAPACITY; i++) tree_slots[i] = '0;
    end

    // walk the local tree copy, insert on an empty slot
    function automatic t_walk_result walk_tree(t_mode mode, t_key key);
        t_walk_result r;
        int unsigned  pos;
        int unsigned  descents;
        bit           hit;
        bit           done;
        t_key         v;
        r = '{default: '0};
        pos = 0;
        descents = 0;
        hit = 1'b0;
        done = 1'b0;
        if (key == 0) return r;
        while (!done && pos < CAPACITY) begin
            v = tree_slots[pos];
            if (v == 0) begin
                done = 1'b1;
            end else if (v == key) begin
                hit = 1'b1;
                done = 1'b1;
            end else begin
                descents++;
                pos = (key < v) ? 2 * pos + 1 : 2 * pos + 2;
            end
        end
        if (pos >= CAPACITY) begin
            r.overflow = 1'b1;
        end else begin
            r.slot_index = t_slot'(pos);
            if (mode == MODE_FIND) begin
                if (hit) r.found_value = key;
            end else if (hit) begin
                r.was_duplicate = 1'b1;
                r.compare_count = (descents + 1 > CNT_MAX) ? t_cnt'(CNT_MAX)
                                                           : t_cnt'(descents + 1);
            end else begin
                tree_slots[pos] = key;
            end
        end
        return r;
    endfunction

    function automatic bit skip_cycle();
        if (reqs_accepted >= QUIET_FROM && reqs_accepted < QUIET_TO) return 1'b0;
        return $urandom_range(0, 99) < 14;
    endfunction

    function automatic t_key random_key();
        if ($urandom_range(0, 1)) return t_key'($urandom);
        return t_key'(int'($urandom_range(0, 4000)) - 2000);
    endfunction

    function automatic t_key pool_key();
        return queued_keys[$urandom_range(0, queued_keys.size() - 1)];
    endfunction

    task automatic add_req(t_mode mode, t_key key);
        pending_reqs.push_back('{mode: mode, key: key});
        if (mode == MODE_INSERT && key != 0) queued_keys.push_back(key);
    endtask

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch (%s): expected found=%0d dup=%0b cnt=%0d slot=%0d ovf=%0b, got found=%0d dup=%0b cnt=%0d slot=%0d ovf=%0b",
                     what, exp_result.found_value, exp_result.was_duplicate,
                     exp_result.compare_count, exp_result.slot_index,
                     exp_result.overflow, got_result.found_value,
                     got_result.was_duplicate, got_result.compare_count,
                     got_result.slot_index, got_result.overflow);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && req_ch.ready) begin
                due_results.push_back(walk_tree(req_mode, req_key));
                reqs_accepted <= reqs_accepted + 1;
            end
            if (!req_valid || req_ch.ready) begin
                if (pending_reqs.size() > 0 && !skip_cycle()) begin
                    next_req = pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    req_mode  <= next_req.mode;
                    req_key   <= next_req.key;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and response back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_ready && rsp_ch.valid) begin
                got_result.found_value   = rsp_ch.found_value;
                got_result.was_duplicate = rsp_ch.was_duplicate;
                got_result.compare_count = rsp_ch.compare_count;
                got_result.slot_index    = rsp_ch.slot_index;
                got_result.overflow      = rsp_ch.overflow;
                if (due_results.size() == 0) begin
                    exp_result = '{default: '0};
                    report_mismatch("unexpected item");
                end else begin
                    exp_result = due_results.pop_front();
                    if (got_result.found_value !== exp_result.found_value ||
                        got_result.was_duplicate !== exp_result.was_duplicate ||
                        got_result.compare_count !== exp_result.compare_count ||
                        got_result.slot_index !== exp_result.slot_index ||
                        got_result.overflow !== exp_result.overflow)
                        report_mismatch("field");
                end
            end
            if (!pressure_done && reqs_accepted >= HOLD_AT) begin
                pressure_done <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                rsp_ready     <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= !skip_cycle();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_valid && req_ch.ready) || (rsp_ready && rsp_ch.valid))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("implicit_array_bst_engine regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int   pick;
        t_key k;

        // zero key is a no-op
        add_req(MODE_INSERT, '0);
        add_req(MODE_FIND, '0);
        // root, duplicate at the root, hit and miss
        add_req(MODE_INSERT, t_key'(100));
        add_req(MODE_INSERT, t_key'(100));
        add_req(MODE_FIND, t_key'(100));
        add_req(MODE_FIND, t_key'(50));
        // right spine down to the last level
        for (int v = 200; v <= 900; v += 100) add_req(MODE_INSERT, t_key'(v));
        add_req(MODE_INSERT, t_key'(32'sh7fffffff));
        add_req(MODE_INSERT, t_key'(32'sh7fffffff));
        // walk past capacity with 1000, then the key extremes and -1
        add_req(MODE_INSERT, t_key'(1000));
        add_req(MODE_FIND, t_key'(1000));
        add_req(MODE_INSERT, t_key'(32'sh80000000));
        add_req(MODE_FIND, t_key'(32'sh80000000));
        add_req(MODE_FIND, t_key'(32'sh7fffffff));
        add_req(MODE_FIND, t_key'(-1));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                add_req(MODE_INSERT, random_key());
            end else if (pick < 60) begin
                add_req(MODE_FIND, pool_key());
            end else if (pick < 70) begin
                add_req(MODE_INSERT, pool_key());
            end else if (pick < 90) begin
                add_req(MODE_FIND, random_key());
            end else if (pick < 95) begin
                add_req(t_mode'($urandom_range(0, 1)), '0);
            end else begin
                case ($urandom_range(0, 3))
                    0: k = t_key'(32'sh7fffffff);
                    1: k = t_key'(32'sh80000000);
                    2: k = t_key'(1);
                    default: k = t_key'(-1);
                endcase
                add_req(t_mode'($urandom_range(0, 1)), k);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && due_results.size() == 0)
            $display("implicit_array_bst_engine regression: pass");
        else
            $display("implicit_array_bst_engine regression: fail");
        $finish;
    end

endmodule
